[hdl/lese_pkg.sv]
`timescale 1ns / 1ps
// Package for the linear elastic stress and energy unit.
// Holds the fixed datapath widths, element codes and register codes; no dependencies.
package lese_pkg;

    // Port widths.
    localparam int DATA_W    = 32;
    localparam int ENERGY_W  = 48;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    // Internal widths, valid for every fraction width from 8 to 24.
    localparam int S_W     = 34;            // twice the strain, |s| < 2^33
    localparam int TR_W    = 35;            // twice the trace, |tr2| < 2^34
    localparam int P_W     = 66;            // 2*mu*s and lambda*tr2
    localparam int ACC_W   = 67;            // 2*mu*s + lambda*tr2
    localparam int RND_W   = 68;            // accumulator after adding the rounding half
    localparam int Q_W     = 66;            // s^2
    localparam int PAIR_W  = 68;            // sum of three squares
    localparam int SQ_W    = 70;            // sum of all nine squares
    localparam int TQ_W    = 68;            // tr2^2
    localparam int LIMB_W  = 32;
    localparam int SQ_HI_W = SQ_W - 2 * LIMB_W;
    localparam int TQ_HI_W = TQ_W - 2 * LIMB_W;
    localparam int MUL_W   = 2 * LIMB_W;
    localparam int M2_W    = SQ_HI_W + LIMB_W;
    localparam int L_W     = LIMB_W + CFG_W;
    localparam int L2_W    = TQ_HI_W + CFG_W;
    localparam int AB_W    = MUL_W + 1;
    localparam int C_W     = M2_W + 1;
    localparam int E_W     = 104;           // 8*psi scaled, below 2^103

    // The strain is symmetric, so six distinct elements are carried.
    localparam int NUM_SYM = 6;
    localparam int SYM_00  = 0;
    localparam int SYM_11  = 1;
    localparam int SYM_22  = 2;
    localparam int SYM_01  = 3;
    localparam int SYM_02  = 4;
    localparam int SYM_12  = 5;
    localparam int NUM_DIAG = 3;

    localparam int NUM_STAGES = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEAR_MODULUS = 1'b0,
        REG_LAME_LAMBDA   = 1'b1
    } t_cfg_reg;

    typedef logic signed [S_W-1:0]    t_strain;
    typedef logic signed [DATA_W-1:0] t_stress;

endpackage

[hdl/linear_elastic_stress_energy_unit.sv]
`timescale 1ns / 1ps
// Top level of the linear elastic stress and energy unit: an eight stage pipeline.
// Depends on lese_pkg for widths, element codes and register codes.

// Takes one deformation gradient per cycle and returns the first Piola stress of small
// strain linear elasticity and the strain energy density. Every stage holds a valid
// bit and advances whenever the stage after it can take its contents, so a stall at
// the output fills bubbles first and only then pushes back to the input; with no
// stall the unit sustains one transfer per cycle. The eight stages follow the energy
// path: strain, products and squares, two adder stages for the square sum, 32 bit limb
// products, limb sums, recombination and the final rounding; the stress is ready after
// four and is carried along to match. Shear modulus and lambda must be written through
// the register port only while the pipeline is empty; the unit leaves it to the user.
module linear_elastic_stress_energy_unit
    import lese_pkg::*;
#(
    parameter int DIM       = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [DATA_W-1:0]    i_f_r0c0,
    input  logic signed [DATA_W-1:0]    i_f_r0c1,
    input  logic signed [DATA_W-1:0]    i_f_r0c2,
    input  logic signed [DATA_W-1:0]    i_f_r1c0,
    input  logic signed [DATA_W-1:0]    i_f_r1c1,
    input  logic signed [DATA_W-1:0]    i_f_r1c2,
    input  logic signed [DATA_W-1:0]    i_f_r2c0,
    input  logic signed [DATA_W-1:0]    i_f_r2c1,
    input  logic signed [DATA_W-1:0]    i_f_r2c2,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [DATA_W-1:0]    o_stress_r0c0,
    output logic signed [DATA_W-1:0]    o_stress_r0c1,
    output logic signed [DATA_W-1:0]    o_stress_r0c2,
    output logic signed [DATA_W-1:0]    o_stress_r1c0,
    output logic signed [DATA_W-1:0]    o_stress_r1c1,
    output logic signed [DATA_W-1:0]    o_stress_r1c2,
    output logic signed [DATA_W-1:0]    o_stress_r2c0,
    output logic signed [DATA_W-1:0]    o_stress_r2c1,
    output logic signed [DATA_W-1:0]    o_stress_r2c2,
    output logic [ENERGY_W-1:0]         o_energy_density
);

    localparam bit HAS_Z = (DIM > 2);
    localparam logic signed [S_W-1:0]   DIAG_OFS  = S_W'(2) <<< FRAC_BITS;
    localparam logic signed [RND_W-1:0] S_HALF    = RND_W'(1) <<< FRAC_BITS;
    localparam logic [E_W:0]            E_HALF    = (E_W + 1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic [CFG_W-1:0]        CFG_ONE   = CFG_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] STRESS_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] STRESS_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    // Configuration.
    logic [CFG_W-1:0] r_shear;
    logic [CFG_W-1:0] r_lambda;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shear  <= CFG_ONE;
            r_lambda <= CFG_ONE;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_SHEAR_MODULUS: r_shear  <= i_cfg_wdata;
                REG_LAME_LAMBDA:   r_lambda <= i_cfg_wdata;
                default:           r_shear  <= r_shear;
            endcase
        end
    end

    logic [CFG_W:0] mu2;
    assign mu2 = {r_shear, 1'b0};

    // Pipeline control: a stage takes new contents when it is empty or its
    // successor moves on.
    logic [NUM_STAGES:1] r_v;
    logic [NUM_STAGES:1] en;

    always_comb begin
        en[NUM_STAGES] = !r_v[NUM_STAGES] || !i_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NUM_STAGES];

    // Stage 1: twice the strain and twice the trace.
    t_strain                 n_s [NUM_SYM];
    logic signed [TR_W-1:0]  n_tr2;
    t_strain                 r_s [NUM_SYM];
    logic signed [TR_W-1:0]  r_tr2;

    always_comb begin
        n_s[SYM_00] = S_W'(i_f_r0c0) + S_W'(i_f_r0c0) - DIAG_OFS;
        n_s[SYM_11] = S_W'(i_f_r1c1) + S_W'(i_f_r1c1) - DIAG_OFS;
        n_s[SYM_01] = S_W'(i_f_r0c1) + S_W'(i_f_r1c0);
        if (HAS_Z) begin
            n_s[SYM_22] = S_W'(i_f_r2c2) + S_W'(i_f_r2c2) - DIAG_OFS;
            n_s[SYM_02] = S_W'(i_f_r0c2) + S_W'(i_f_r2c0);
            n_s[SYM_12] = S_W'(i_f_r1c2) + S_W'(i_f_r2c1);
        end else begin
            n_s[SYM_22] = '0;
            n_s[SYM_02] = '0;
            n_s[SYM_12] = '0;
        end
        n_tr2 = TR_W'(n_s[SYM_00]) + TR_W'(n_s[SYM_11]) + TR_W'(n_s[SYM_22]);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s   <= n_s;
            r_tr2 <= n_tr2;
        end
    end

    // Stage 2: stress products, lambda times trace, and the squares.
    logic signed [P_W-1:0]      n_p [NUM_SYM];
    logic signed [2*S_W-1:0]    n_qf [NUM_SYM];
    logic [Q_W-1:0]             n_q [NUM_SYM];
    logic signed [P_W-1:0]      n_t;
    logic signed [2*TR_W-1:0]   n_tqf;
    logic signed [P_W-1:0]      r_p [NUM_SYM];
    logic [Q_W-1:0]             r_q [NUM_SYM];
    logic signed [P_W-1:0]      r_t;
    logic [TQ_W-1:0]            r_tq2;

    always_comb begin
        for (int k = 0; k < NUM_SYM; k++) begin
            n_p[k]  = P_W'(r_s[k]) * P_W'($signed({1'b0, mu2}));
            n_qf[k] = (2 * S_W)'(r_s[k]) * (2 * S_W)'(r_s[k]);
            n_q[k]  = n_qf[k][Q_W-1:0];
        end
        n_t   = P_W'(r_tr2) * P_W'($signed({1'b0, r_lambda}));
        n_tqf = (2 * TR_W)'(r_tr2) * (2 * TR_W)'(r_tr2);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_p   <= n_p;
            r_q   <= n_q;
            r_t   <= n_t;
            r_tq2 <= n_tqf[TQ_W-1:0];
        end
    end

    // Stage 3: diagonal stresses gain the lambda term; squares are summed in two
    // groups, the off-diagonal group counting twice later.
    logic signed [ACC_W-1:0] n_acc [NUM_SYM];
    logic signed [ACC_W-1:0] r_acc [NUM_SYM];
    logic [PAIR_W-1:0]       r_pa;
    logic [PAIR_W-1:0]       r_pb;
    logic [TQ_W-1:0]         r_tq3;

    always_comb begin
        for (int k = 0; k < NUM_SYM; k++) begin
            n_acc[k] = ACC_W'(r_p[k]);
        end
        for (int k = 0; k < NUM_DIAG; k++) begin
            if (k < 2 || HAS_Z) begin
                n_acc[k] = ACC_W'(r_p[k]) + ACC_W'(r_t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_acc <= n_acc;
            r_pa  <= PAIR_W'(r_q[SYM_00]) + PAIR_W'(r_q[SYM_11]) + PAIR_W'(r_q[SYM_22]);
            r_pb  <= PAIR_W'(r_q[SYM_01]) + PAIR_W'(r_q[SYM_02]) + PAIR_W'(r_q[SYM_12]);
            r_tq3 <= r_tq2;
        end
    end

    // Stage 4: stress rounding and saturation; full square sum.
    logic signed [RND_W-1:0] n_rnd [NUM_SYM];
    logic signed [RND_W-1:0] n_sh [NUM_SYM];
    t_stress                 n_st [NUM_SYM];
    t_stress                 r_st [4:NUM_STAGES][NUM_SYM];
    logic [SQ_W-1:0]         r_sq;
    logic [TQ_W-1:0]         r_tq4;

    always_comb begin
        for (int k = 0; k < NUM_SYM; k++) begin
            n_rnd[k] = RND_W'(r_acc[k]) + S_HALF;
            n_sh[k]  = n_rnd[k] >>> (FRAC_BITS + 1);
            // In range when every bit above the result's sign matches that sign.
            if ((&n_sh[k][RND_W-1:DATA_W-1]) || !(|n_sh[k][RND_W-1:DATA_W-1])) begin
                n_st[k] = n_sh[k][DATA_W-1:0];
            end else if (n_sh[k][RND_W-1]) begin
                n_st[k] = STRESS_MIN;
            end else begin
                n_st[k] = STRESS_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_st[4] <= n_st;
            r_sq    <= SQ_W'(r_pa) + (SQ_W'(r_pb) << 1);
            r_tq4   <= r_tq3;
        end
        for (int k = 5; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
                r_st[k] <= r_st[k - 1];
            end
        end
    end

    // Stage 5: 32 bit limb products of the energy terms.
    logic [MUL_W-1:0] r_m0;
    logic [MUL_W-1:0] r_m1;
    logic [M2_W-1:0]  r_m2;
    logic [L_W-1:0]   r_l0;
    logic [L_W-1:0]   r_l1;
    logic [L2_W-1:0]  r_l2;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_m0 <= MUL_W'(r_sq[LIMB_W-1:0]) * MUL_W'(mu2);
            r_m1 <= MUL_W'(r_sq[2*LIMB_W-1:LIMB_W]) * MUL_W'(mu2);
            r_m2 <= M2_W'(r_sq[SQ_W-1:2*LIMB_W]) * M2_W'(mu2);
            r_l0 <= L_W'(r_tq4[LIMB_W-1:0]) * L_W'(r_lambda);
            r_l1 <= L_W'(r_tq4[2*LIMB_W-1:LIMB_W]) * L_W'(r_lambda);
            r_l2 <= L2_W'(r_tq4[TQ_W-1:2*LIMB_W]) * L2_W'(r_lambda);
        end
    end

    // Stage 6: add the shear and lambda limbs of equal weight.
    logic [AB_W-1:0] r_ea;
    logic [AB_W-1:0] r_eb;
    logic [C_W-1:0]  r_ec;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_ea <= AB_W'(r_m0) + AB_W'(r_l0);
            r_eb <= AB_W'(r_m1) + AB_W'(r_l1);
            r_ec <= C_W'(r_m2) + C_W'(r_l2);
        end
    end

    // Stage 7: recombine the limbs into eight times the energy density.
    logic [E_W-1:0] r_e;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_e <= E_W'(r_ea) + (E_W'(r_eb) << LIMB_W) + (E_W'(r_ec) << (2 * LIMB_W));
        end
    end

    // Stage 8: round, drop the scale and saturate.
    logic [E_W:0]          n_erd;
    logic [E_W:0]          n_esh;
    logic [ENERGY_W-1:0]   r_energy;

    assign n_erd = {1'b0, r_e} + E_HALF;
    assign n_esh = n_erd >> (2 * FRAC_BITS + 3);

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            if (|n_esh[E_W:ENERGY_W]) begin
                r_energy <= '1;
            end else begin
                r_energy <= n_esh[ENERGY_W-1:0];
            end
        end
    end

    // The stress is symmetric; mirrored outputs share a register.
    assign o_stress_r0c0    = r_st[NUM_STAGES][SYM_00];
    assign o_stress_r1c1    = r_st[NUM_STAGES][SYM_11];
    assign o_stress_r2c2    = r_st[NUM_STAGES][SYM_22];
    assign o_stress_r0c1    = r_st[NUM_STAGES][SYM_01];
    assign o_stress_r1c0    = r_st[NUM_STAGES][SYM_01];
    assign o_stress_r0c2    = r_st[NUM_STAGES][SYM_02];
    assign o_stress_r2c0    = r_st[NUM_STAGES][SYM_02];
    assign o_stress_r1c2    = r_st[NUM_STAGES][SYM_12];
    assign o_stress_r2c1    = r_st[NUM_STAGES][SYM_12];
    assign o_energy_density = r_energy;

    // Back pressure reaches the input only once the first stage is occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[1])
        else $error("input stalled while the first stage is empty");

    // A blocked middle stage keeps both its item and its energy sum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !en[5]) |=> (r_v[4] && $stable(r_sq) && $stable(r_tq4)))
        else $error("blocked stage lost or changed its contents");

    // In two dimensions the third row and column of the stress are zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !HAS_Z) |-> (o_stress_r2c2 == '0 && o_stress_r0c2 == '0
                                 && o_stress_r1c2 == '0))
        else $error("third row of stress nonzero in two dimensions");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for linear_elastic_stress_energy_unit: directed gradients, then
// random ones under several moduli; each result compared with a predictor or listed value.
// Depends on lese_pkg and the unit's RTL.
module tb_top;
    import lese_pkg::*;

    localparam int GRAD_DIM       = 3;
    localparam int Q_FRAC         = 16;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 270;
    localparam int LONG_HOLD      = 60;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef logic [0:8][DATA_W-1:0] t_mat;

    typedef struct packed {
        t_mat                stress;
        logic [ENERGY_W-1:0] energy;
    } t_piola_energy;

    typedef struct packed {
        t_mat                grad;
        logic                known;
        t_mat                stress;
        logic [ENERGY_W-1:0] energy;
    } t_dir_row;

    localparam logic [31:0] Z_Q    = 32'h0000_0000;
    localparam logic [31:0] ONE_Q  = 32'h0001_0000;
    localparam logic [31:0] TWO_Q  = 32'h0002_0000;
    localparam logic [31:0] NEG1_Q = 32'hFFFF_0000;
    localparam logic [31:0] NEG5_Q = 32'hFFFB_0000;
    localparam logic [31:0] MAX_Q  = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q  = 32'h8000_0000;
    localparam logic [47:0] E_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;

    localparam t_mat M_ZERO  = {9{Z_Q}};
    localparam t_mat M_IDENT = {ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q};
    localparam t_mat M_MAX   = {9{MAX_Q}};
    localparam t_mat M_MIN   = {9{MIN_Q}};

    localparam int NUM_DIR = 21;

    // Results are spelled out only for the identity, the zero gradient and the
    // saturating extremes; everything else goes through the predictor.
    t_dir_row dir_rows [NUM_DIR] = '{
        {M_IDENT, 1'b1, M_ZERO, 48'd0},
        {M_ZERO, 1'b1, {NEG5_Q, Z_Q, Z_Q, Z_Q, NEG5_Q, Z_Q, Z_Q, Z_Q, NEG5_Q}, 48'd491520},
        {M_MAX, 1'b1, M_MAX, E_MAX},
        {M_MIN, 1'b1, M_MIN, E_MAX},
        {{ONE_Q, MAX_Q, Z_Q, MIN_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, 32'h8000, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{TWO_Q, Z_Q, Z_Q, Z_Q, TWO_Q, Z_Q, Z_Q, Z_Q, TWO_Q}, 1'b0, M_ZERO, 48'd0},
        {{NEG1_Q, Z_Q, Z_Q, Z_Q, NEG1_Q, Z_Q, Z_Q, Z_Q, NEG1_Q}, 1'b0, M_ZERO, 48'd0},
        {{32'h0001_0001, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{32'h0000_FFFF, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, 32'h1, 32'hFFFF_FFFF, Z_Q, ONE_Q, 32'h3, 32'h5, Z_Q, ONE_Q},
         1'b0, M_ZERO, 48'd0},
        {{Z_Q, NEG1_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{MAX_Q, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, MIN_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, MAX_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, MIN_Q, ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, Z_Q, MAX_Q, Z_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q, MIN_Q, Z_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, MAX_Q, Z_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, MIN_Q, ONE_Q}, 1'b0, M_ZERO, 48'd0},
        {{ONE_Q, Z_Q, Z_Q, Z_Q, ONE_Q, Z_Q, Z_Q, Z_Q, MAX_Q}, 1'b0, M_ZERO, 48'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic i_valid;
    logic i_stall;
    t_mat grad_in;
    wire o_stall;
    wire o_valid;
    wire [0:8][DATA_W-1:0] stress_out;
    wire [ENERGY_W-1:0] energy_out;

    // Predictor's copy of the moduli.
    logic [CFG_W-1:0] mu_q;
    logic [CFG_W-1:0] lam_q;

    t_piola_energy pending_results[$];
    int fail_cnt     = 0;
    int grads_sent   = 0;
    int results_seen = 0;
    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    linear_elastic_stress_energy_unit #(
        .DIM       (GRAD_DIM),
        .FRAC_BITS (Q_FRAC)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_f_r0c0         (grad_in[0]),
        .i_f_r0c1         (grad_in[1]),
        .i_f_r0c2         (grad_in[2]),
        .i_f_r1c0         (grad_in[3]),
        .i_f_r1c1         (grad_in[4]),
        .i_f_r1c2         (grad_in[5]),
        .i_f_r2c0         (grad_in[6]),
        .i_f_r2c1         (grad_in[7]),
        .i_f_r2c2         (grad_in[8]),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_stress_r0c0    (stress_out[0]),
        .o_stress_r0c1    (stress_out[1]),
        .o_stress_r0c2    (stress_out[2]),
        .o_stress_r1c0    (stress_out[3]),
        .o_stress_r1c1    (stress_out[4]),
        .o_stress_r1c2    (stress_out[5]),
        .o_stress_r2c0    (stress_out[6]),
        .o_stress_r2c1    (stress_out[7]),
        .o_stress_r2c2    (stress_out[8]),
        .o_energy_density (energy_out)
    );

    // Stress and energy density of one gradient, computed exactly in wide integers and
    // rounded once at the end, half toward plus infinity.
    function automatic t_piola_energy predict_piola_energy(input t_mat g);
        logic signed [63:0]  s2 [0:2][0:2];
        logic signed [127:0] tw;
        logic signed [127:0] sw;
        logic signed [127:0] mu2;
        logic signed [127:0] lam;
        logic signed [127:0] acc;
        logic signed [127:0] en;
        t_piola_energy r;
        tw  = '0;
        en  = '0;
        mu2 = $signed({96'd0, mu_q, 1'b0});
        lam = $signed({97'd0, lam_q});
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s2[i][j] = '0;
                if (i < GRAD_DIM && j < GRAD_DIM) begin
                    s2[i][j] = $signed(g[i*3+j]) + $signed(g[j*3+i]);
                    if (i == j)
                        s2[i][j] = s2[i][j] - (64'sd2 <<< Q_FRAC);
                end
            end
        end
        for (int i = 0; i < GRAD_DIM; i++)
            tw = tw + s2[i][i];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sw = s2[i][j];
                en = en + sw * sw;
                r.stress[i*3+j] = '0;
                if (i < GRAD_DIM && j < GRAD_DIM) begin
                    acc = sw * mu2;
                    if (i == j)
                        acc = acc + tw * lam;
                    acc = (acc + (128'sd1 <<< Q_FRAC)) >>> (Q_FRAC + 1);
                    if (acc > 128'sd2147483647)
                        r.stress[i*3+j] = MAX_Q;
                    else if (acc < -128'sd2147483648)
                        r.stress[i*3+j] = MIN_Q;
                    else
                        r.stress[i*3+j] = acc[31:0];
                end
            end
        end
        en = en * mu2 + tw * tw * lam;
        en = (en + (128'sd1 <<< (2 * Q_FRAC + 2))) >>> (2 * Q_FRAC + 3);
        r.energy = (en > $signed({80'd0, E_MAX})) ? E_MAX : en[47:0];
        return r;
    endfunction

    // Mostly near-identity gradients, some fully random, some built from extremes.
    function automatic t_mat rand_gradient();
        t_mat g;
        int style;
        logic [31:0] base;
        style = $urandom_range(0, 19);
        for (int k = 0; k < 9; k++) begin
            base = (k % 4 == 0) ? ONE_Q : Z_Q;
            if (style < 12)
                g[k] = base + $urandom_range(0, 1 << 19) - (1 << 18);
            else if (style < 17)
                g[k] = $urandom();
            else begin
                case ($urandom_range(0, 4))
                    0: g[k] = MAX_Q;
                    1: g[k] = MIN_Q;
                    2: g[k] = Z_Q;
                    3: g[k] = 32'hFFFF_FFFF;
                    default: g[k] = $urandom();
                endcase
            end
        end
        return g;
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SHEAR_MODULUS: mu_q  = val;
            REG_LAME_LAMBDA:   lam_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Entered and left at a falling edge.
    task automatic send_gradient(input t_mat g, input t_piola_energy want);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        grad_in <= g;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
        grads_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (NUM_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("MISMATCH at %0t: %s expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_piola_energy want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no gradient outstanding", 64'd0, 64'd0);
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < 9; k++)
                    if (stress_out[k] !== want.stress[k])
                        flag_mismatch($sformatf("stress r%0dc%0d", k / 3, k % 3),
                                      want.stress[k], stress_out[k]);
                if (energy_out !== want.energy)
                    flag_mismatch("energy density", want.energy, energy_out);
            end
        end
    end

    // Output back-pressure: short random bursts, plus one long hold on request.
    initial begin : stall_gen
        int n;
        bit held;
        i_stall = 1'b0;
        held    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                for (n = 0; n < LONG_HOLD; n++)
                    @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin : main_seq
        t_piola_energy want;
        t_mat g;
        logic [CFG_W-1:0] mu_w;
        logic [CFG_W-1:0] lam_w;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr  = REG_SHEAR_MODULUS;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        grad_in     = M_IDENT;
        mu_q        = 31'(1) << Q_FRAC;
        lam_q       = 31'(1) << Q_FRAC;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part runs on the moduli left by reset.
        for (int n = 0; n < NUM_DIR; n++) begin
            if (dir_rows[n].known)
                want = {dir_rows[n].stress, dir_rows[n].energy};
            else
                want = predict_piola_energy(dir_rows[n].grad);
            send_gradient(dir_rows[n].grad, want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            case (p)
                0: begin mu_w = '0;      lam_w = '0;      end
                1: begin mu_w = CFG_MAX; lam_w = CFG_MAX; end
                2: begin mu_w = CFG_MAX; lam_w = '0;      end
                3: begin mu_w = '0;      lam_w = CFG_MAX; end
                4: begin
                    mu_w  = CFG_W'($urandom());
                    lam_w = CFG_W'($urandom());
                end
                5: begin
                    mu_w  = CFG_W'($urandom_range(0, 4 << Q_FRAC));
                    lam_w = CFG_W'($urandom_range(0, 4 << Q_FRAC));
                end
                default: begin
                    mu_w  = 31'(1) << Q_FRAC;
                    lam_w = 31'(3) << (Q_FRAC - 1);
                end
            endcase
            write_reg(REG_SHEAR_MODULUS, mu_w);
            write_reg(REG_LAME_LAMBDA, lam_w);
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            // Hold the output long enough that the pipeline fills and stalls the input.
            if (p == 4)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                g = rand_gradient();
                send_gradient(g, predict_piola_energy(g));
            end
        end
        i_valid <= 1'b0;
        drain_pipeline();

        $display("Ran %0d deformation gradients (%0d directed) across %0d modulus settings,",
                 grads_sent, NUM_DIR, NUM_PHASES + 1);
        $display("including zero and full-scale moduli; %0d results compared, %0d mismatches.",
                 results_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
